### rtl/core/mdc_pkg.sv
// shared types, constants and the quarter-wave sine table of the chorus unit
// depends on nothing; mdc_cfg, mdc_lfo and the top level import it
`default_nettype none

package mdc_pkg;

  // sizes
  localparam int DELAY_DEPTH  = 4096;
  localparam int ADDR_BITS    = $clog2(DELAY_DEPTH);
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int QUARTER      = SINE_ENTRIES / 4;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;
  localparam int COEF_BITS    = FRAC_BITS + 1;
  localparam int SINE_W       = 16;
  localparam int DELAY_W      = 28;
  localparam int SWING_W      = SINE_W + DELAY_W + 1 - 15;
  localparam int DLY_SUM_W    = SWING_W + 1;
  localparam int RP_W         = ADDR_BITS + FRAC_BITS;
  localparam int EXT_W        = (RP_W > DLY_SUM_W) ? RP_W : DLY_SUM_W;
  localparam int PROD_W       = SAMPLE_BITS + COEF_BITS + 1;
  localparam int ACC_W        = PROD_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_DELAY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SPAN   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MIX          = CFG_IDX_W'(4);

  localparam logic [31:0]          RST_PHASE_STEP   = 32'd89478;
  localparam logic [DELAY_W-1:0]   RST_CENTER_DELAY = DELAY_W'(22020096);
  localparam logic [DELAY_W-1:0]   RST_DEPTH_SPAN   = DELAY_W'(7864320);
  localparam logic [COEF_BITS-1:0] RST_MIX          = COEF_BITS'(32768);

  // unity in Q1.16
  localparam logic [COEF_BITS-1:0] COEF_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic                 enabled;
    logic [31:0]          phase_step;
    logic [DELAY_W-1:0]   center_delay;
    logic [DELAY_W-1:0]   depth_span;
    logic [COEF_BITS-1:0] mix;
  } mdc_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWING,
    ST_ADDR,
    ST_READ,
    ST_WEIGHT0,
    ST_WEIGHT1,
    ST_MIX0,
    ST_MIX1,
    ST_DONE
  } mdc_state_t;

  // pi/2 in Q61
  localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
  // pi/2 in Q61 split by the table size
  localparam logic [63:0] HP_QUOT     = HALF_PI_Q61 / SINE_ENTRIES;
  localparam logic [63:0] HP_REM      = HALF_PI_Q61 % SINE_ENTRIES;

  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // unsigned shift-subtract quotient, only used while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767 * sin(pi/2 * t / SINE_ENTRIES)), taylor series in Q61
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] t);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  dv;
    logic [127:0] r;
    x    = HP_QUOT * t + ((HP_REM * t) >> SINE_BITS);
    x2   = mul_q61(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        dv   = 64'(4 * k * k + 2 * k);
        term = udiv64(mul_q61(term, x2), dv);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    r = ({64'd0, sum} * 128'd32767 + (128'd1 << 60)) >> 61;
    return r[SINE_W-1:0];
  endfunction

  typedef logic [SINE_W-1:0] qsine_tab_t [0:QUARTER];

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int j = 0; j <= QUARTER; j++) begin
      tab[j] = quarter_sine(64'(4 * j));
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  localparam logic [SINE_BITS-2:0] QUARTER_K = (SINE_BITS-1)'(QUARTER);

  // full-wave lookup folded onto the quarter table
  function automatic logic signed [SINE_W-1:0] sine_at(input logic [SINE_BITS-1:0] k);
    logic [SINE_BITS-2:0] kq;
    logic [SINE_BITS-2:0] j;
    logic [SINE_W-1:0]    v;
    kq = k[SINE_BITS-2:0];
    j  = (kq > QUARTER_K) ? ((SINE_BITS-1)'(0) - kq) : kq;
    v  = QSINE[j];
    return k[SINE_BITS-1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

`default_nettype wire

### rtl/core/mdc_ram.sv
// generic single-clock ram, one write port and one registered read port
// standalone, no package needed
`default_nettype none

module mdc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/mdc_cfg.sv
// configuration register file of the chorus unit
// depends on mdc_pkg
`default_nettype none

module mdc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output mdc_pkg::mdc_cfg_t                  cfg
);
  import mdc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled      <= 1'b0;
      cfg.phase_step   <= RST_PHASE_STEP;
      cfg.center_delay <= RST_CENTER_DELAY;
      cfg.depth_span   <= RST_DEPTH_SPAN;
      cfg.mix          <= RST_MIX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED:      cfg.enabled      <= cfg_data[0];
        REG_PHASE_STEP:   cfg.phase_step   <= cfg_data[31:0];
        REG_CENTER_DELAY: cfg.center_delay <= cfg_data[DELAY_W-1:0];
        REG_DEPTH_SPAN:   cfg.depth_span   <= cfg_data[DELAY_W-1:0];
        REG_MIX:          cfg.mix          <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/mdc_lfo.sv
// sine lfo: phase accumulator, sine lookup and depth scaling
// depends on mdc_pkg
`default_nettype none

module mdc_lfo (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic [31:0]                       phase_step,
  input  wire logic [mdc_pkg::DELAY_W-1:0]       depth_span,
  output logic signed [mdc_pkg::SWING_W-1:0]     swing
);
  import mdc_pkg::*;

  localparam int MUL_W = SINE_W + DELAY_W + 1;

  logic [31:0]              lfo_phase;
  logic signed [SINE_W-1:0] sine;
  logic signed [MUL_W-1:0]  prod;

  // sine taken at the old phase, then the phase moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= 32'd0;
    end else if (advance) begin
      lfo_phase <= lfo_phase + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sine <= sine_at(lfo_phase[31 -: SINE_BITS]);
    end
    prod <= MUL_W'(sine) * $signed({1'b0, depth_span});
  end

  // arithmetic shift right by 15
  assign swing = prod[MUL_W-1:15];

endmodule

`default_nettype wire

### rtl/core/modulated_delay_chorus_unit.sv
// top level of the modulated delay chorus
// depends on mdc_pkg, mdc_ram, mdc_cfg and mdc_lfo
`default_nettype none

// Mono chorus on a stream of signed 24-bit samples. Each input transaction
// gives exactly one output transaction. While disabled, samples pass through
// unchanged and the delay line, write pointer and lfo phase hold. While
// enabled, the sample is written into a 4096-entry delay ram, a sine lfo
// sweeps the delay around center_delay by up to depth_span (both Q12.16
// samples), the delayed signal is read from two neighbor entries and
// interpolated with the 16-bit fraction, and the result is mixed with the
// dry sample by mix (Q1.16, values above 1.0 act as 1.0). An enabled item
// steps through the swing, addr, read, weight0, weight1, mix0, mix1 and
// done states, and its result is loaded into the output register in the
// done step; a disabled item goes from idle straight to done. The enabled
// steps are set by the lfo depth multiply, by the single read port of the
// delay ram, which fetches the two neighbors one after the other, and by
// one shared 24x18 multiplier that does the four weightings in turn. One
// item is in flight at a time; the output register lets the next item
// enter while a result waits, and a result still waiting there holds the
// next item in its last step. Delay ram entries not yet written since
// reset read as zero through a fill count, so no clearing pass is needed.
// Configuration writes are always accepted and take effect at once; write
// them only while no item is in flight.

module modulated_delay_chorus_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [23:0]                    s_tdata,   // [23:0] sample_in
  // output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [23:0]                         m_tdata,   // [23:0] sample_out
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mdc_pkg::*;

  mdc_cfg_t   cfg;
  mdc_state_t state, state_next;

  // handshake and sequencing strobes
  logic in_take;
  logic out_load;
  logic lfo_advance;
  logic ram_we;

  // pointers and fill tracking
  logic [ADDR_BITS-1:0] wp;
  logic [ADDR_BITS:0]   fill;

  // lfo swing and read point
  logic signed [SWING_W-1:0]   swing;
  logic signed [DLY_SUM_W-1:0] delay;
  logic signed [EXT_W-1:0]     delay_ext;
  logic [RP_W-1:0]             rp;
  logic [ADDR_BITS-1:0]        idx0;
  logic [ADDR_BITS-1:0]        idx1;
  logic [ADDR_BITS-1:0]        ram_raddr;
  logic [SAMPLE_BITS-1:0]      ram_rdata;
  logic [FRAC_BITS-1:0]        frac;
  logic                        valid0;
  logic                        valid1;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] s0;   // first neighbor, later the wet sample
  logic signed [SAMPLE_BITS-1:0] s1;
  logic signed [ACC_W-1:0]       acc;

  // shared multiplier
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic [COEF_BITS-1:0]          mul_b;
  logic                          mul_acc;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [ACC_W-1:0]       acc_sum;
  logic [COEF_BITS-1:0]          wet_w;

  mdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdc_lfo u_lfo (
    .clk        (clk),
    .rst        (rst),
    .advance    (lfo_advance),
    .phase_step (cfg.phase_step),
    .depth_span (cfg.depth_span),
    .swing      (swing)
  );

  mdc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (s_tdata[SAMPLE_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = cfg.enabled ? ST_SWING : ST_DONE;
        end
      end
      ST_SWING:   state_next = ST_ADDR;
      ST_ADDR:    state_next = ST_READ;
      ST_READ:    state_next = ST_WEIGHT0;
      ST_WEIGHT0: state_next = ST_WEIGHT1;
      ST_WEIGHT1: state_next = ST_MIX0;
      ST_MIX0:    state_next = ST_MIX1;
      ST_MIX1:    state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_take     = s_tvalid && s_tready;
  assign ram_we      = in_take && cfg.enabled;
  assign lfo_advance = ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read point: write pointer minus delay, modulo the store in Q.16
  assign delay     = $signed({{(DLY_SUM_W-DELAY_W){1'b0}}, cfg.center_delay})
                     + DLY_SUM_W'(swing);
  assign delay_ext = EXT_W'(delay);
  assign rp        = {wp, {FRAC_BITS{1'b0}}} - delay_ext[RP_W-1:0];
  assign idx0      = rp[RP_W-1:FRAC_BITS];
  assign ram_raddr = (state == ST_ADDR) ? idx0 : idx1;

  // entries beyond the fill count were never written and read as zero
  assign valid0 = fill[ADDR_BITS] || ({1'b0, idx0} < fill);
  assign valid1 = fill[ADDR_BITS] || ({1'b0, idx1} < fill);

  // mix saturates at fully wet
  assign wet_w = (cfg.mix[COEF_BITS-1] && (cfg.mix[FRAC_BITS-1:0] != '0)) ? COEF_ONE : cfg.mix;

  // multiplier operands by step
  always_comb begin
    mul_a   = s0;
    mul_b   = '0;
    mul_acc = 1'b0;
    case (state)
      ST_WEIGHT0: begin
        mul_a = s0;
        mul_b = COEF_ONE - {1'b0, frac};
      end
      ST_WEIGHT1: begin
        mul_a   = s1;
        mul_b   = {1'b0, frac};
        mul_acc = 1'b1;
      end
      ST_MIX0: begin
        mul_a = x;
        mul_b = COEF_ONE - wet_w;
      end
      ST_MIX1: begin
        mul_a   = s0;
        mul_b   = wet_w;
        mul_acc = 1'b1;
      end
      default: ;
    endcase
  end

  assign mul_p   = PROD_W'(mul_a) * $signed({1'b0, mul_b});
  assign acc_sum = (mul_acc ? acc : ACC_W'(0)) + ACC_W'(mul_p);

  // write pointer and fill count move only on enabled items
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else begin
      if (ram_we && !fill[ADDR_BITS]) begin
        fill <= fill + 1'b1;
      end
      if (out_load && cfg.enabled) begin
        wp <= wp + 1'b1;
      end
    end
  end

  // datapath, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      x <= $signed(s_tdata[SAMPLE_BITS-1:0]);
    end
    case (state)
      ST_ADDR: begin
        idx1 <= idx0 + 1'b1;
        frac <= rp[FRAC_BITS-1:0];
        s0   <= valid0 ? '1 : '0;   // mask held until the data arrives
      end
      ST_READ: begin
        s0 <= s0 & $signed(ram_rdata);
        s1 <= valid1 ? '1 : '0;
      end
      ST_WEIGHT0: begin
        s1  <= s1 & $signed(ram_rdata);
        acc <= acc_sum;
      end
      ST_WEIGHT1: acc <= acc_sum;
      ST_MIX0: begin
        s0  <= acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];   // wet sample
        acc <= acc_sum;
      end
      ST_MIX1:    acc <= acc_sum;
      default: ;
    endcase
  end

  // output register parts the two stream sides
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= cfg.enabled ? acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS] : x;
    end
  end

endmodule

`default_nettype wire
